// File: sv/i2cms_pkg.sv
// Package for the I2C master bit sequencer.
// Holds the command codes, beat index type and the per-beat result struct.
// No dependencies.
`default_nettype none

package i2cms_pkg;

    localparam int BEAT_W      = 5;
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 16;

    typedef logic [BEAT_W-1:0] t_beat_idx;

    localparam t_beat_idx WRITE_LAST_BEAT = t_beat_idx'(17);
    localparam t_beat_idx READ_LAST_BEAT  = t_beat_idx'(15);

    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_WRITE     = 3'd2,
        CMD_READ      = 3'd3,
        CMD_WAIT_ACK  = 3'd4,
        CMD_SEND_ACK  = 3'd5,
        CMD_SEND_NACK = 3'd6
    } t_cmd;

    typedef struct packed {
        logic       emit;
        logic       last;
        logic       scl;
        logic       sda;
        logic [7:0] read_byte;
        logic       ack_level;
    } t_beat;

endpackage

`default_nettype wire

// File: sv/i2cms_beat_gen.sv
// Pin-state generator for one beat of an I2C command run.
// Maps command, beat index and current bus levels to one result item.
// Depends on i2cms_pkg.
`default_nettype none

module i2cms_beat_gen (
    input  wire logic [2:0]          i_cmd,
    input  wire i2cms_pkg::t_beat_idx i_beat,
    input  wire logic [7:0]          i_write_byte,
    input  wire logic [7:0]          i_bus_bits,
    input  wire logic                i_bus_ack,
    input  wire logic                i_scl_cur,
    input  wire logic                i_sda_cur,
    output i2cms_pkg::t_beat         o_beat
);

    i2cms_pkg::t_beat_idx w_beat_m1;
    logic [2:0]           w_bit_sel;

    assign w_beat_m1 = i_beat - i2cms_pkg::t_beat_idx'(1);
    assign w_bit_sel = ~w_beat_m1[3:1];

    always_comb begin
        o_beat           = '0;
        o_beat.emit      = 1'b1;
        o_beat.scl       = i_scl_cur;
        o_beat.sda       = i_sda_cur;
        case (i2cms_pkg::t_cmd'(i_cmd))
            i2cms_pkg::CMD_START: begin
                o_beat.scl  = 1'b1;
                o_beat.sda  = (i_beat == '0);
                o_beat.last = (i_beat != '0);
            end
            i2cms_pkg::CMD_STOP: begin
                o_beat.scl  = 1'b1;
                o_beat.sda  = (i_beat != '0);
                o_beat.last = (i_beat != '0);
            end
            i2cms_pkg::CMD_WRITE: begin
                if (i_beat == '0) begin
                    o_beat.scl = 1'b0;
                end else if (i_beat == i2cms_pkg::WRITE_LAST_BEAT) begin
                    o_beat.scl  = 1'b0;
                    o_beat.sda  = 1'b1;
                    o_beat.last = 1'b1;
                end else begin
                    o_beat.scl = i_beat[0];
                    o_beat.sda = i_write_byte[w_bit_sel];
                end
            end
            i2cms_pkg::CMD_READ: begin
                o_beat.scl  = ~i_beat[0];
                o_beat.last = (i_beat == i2cms_pkg::READ_LAST_BEAT);
                if (i_beat == i2cms_pkg::READ_LAST_BEAT) begin
                    o_beat.read_byte = i_bus_bits;
                end
            end
            i2cms_pkg::CMD_WAIT_ACK, i2cms_pkg::CMD_SEND_NACK: begin
                o_beat.sda = 1'b1;
                if (i_beat == i2cms_pkg::t_beat_idx'(1)) begin
                    o_beat.scl = 1'b1;
                end else if (i_beat != '0) begin
                    o_beat.scl  = 1'b0;
                    o_beat.last = 1'b1;
                    if (i2cms_pkg::t_cmd'(i_cmd) == i2cms_pkg::CMD_WAIT_ACK) begin
                        o_beat.ack_level = i_bus_ack;
                    end
                end
            end
            i2cms_pkg::CMD_SEND_ACK: begin
                o_beat.sda = 1'b0;
                if (i_beat == i2cms_pkg::t_beat_idx'(1)) begin
                    o_beat.scl = 1'b1;
                end else if (i_beat == i2cms_pkg::t_beat_idx'(2)) begin
                    o_beat.scl = 1'b0;
                end else if (i_beat != '0) begin
                    o_beat.scl  = 1'b0;
                    o_beat.sda  = 1'b1;
                    o_beat.last = 1'b1;
                end
            end
            default: begin
                o_beat.emit = 1'b0;
                o_beat.last = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/i2cms_out_stage.sv
// Output register of the I2C master bit sequencer.
// Holds one result item until the downstream side takes it.
// Depends on i2cms_pkg.
`default_nettype none

module i2cms_out_stage (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_load,
    input  wire i2cms_pkg::t_beat                    i_beat,
    output logic                                     o_can_load,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // Fields from bit 0: scl, sda, read_byte[7:0], ack_level, zero fill.
    output logic [i2cms_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                     m_axis_tlast
);

    logic                                r_vld;
    logic [i2cms_pkg::OUT_TDATA_W-1:0]   r_data;
    logic                                r_last;

    assign o_can_load = !r_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_can_load) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_data <= {5'd0, i_beat.ack_level, i_beat.read_byte, i_beat.sda, i_beat.scl};
            r_last <= i_beat.last;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_data;
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

// File: sv/i2c_master_bit_sequencer_top.sv
// I2C master bit sequencer, top level.
// Command input register, beat counter, bus level state and output stage.
// Depends on i2cms_pkg, i2cms_beat_gen and i2cms_out_stage.
//
// Usage: each item on the slave channel is one bus command in s_axis_tuser
// (start, stop, write byte, read byte, wait ack, send ack, send nack) with
// the write byte, the sampled read bits and the sampled ack bit in
// s_axis_tdata. The block answers with a run of result items on the master
// channel, one per half-bit period, each carrying the SCL and SDA levels;
// tlast marks the final item of the run, which also carries the read byte
// or the ack level. A run is 2 to 18 items long; the unused command code
// emits nothing and is retired without waiting on the output register.
// The command is held in the command register and each result item passes
// through the output register. One result item per cycle while the receiver
// does not stall. The next command is taken in the same cycle as the last
// item of the current run moves into the output register, so runs follow
// each other without gaps.
// Reset: both bus levels return to released (high) and any pending command
// and result are dropped. When the receiver stalls, the output register
// holds its item and the beat counter waits; the slave channel stalls while
// the command register is occupied and the last item of its run is not out.
`default_nettype none

module i2c_master_bit_sequencer_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // Fields from bit 0: write_byte[7:0], bus_bits[7:0], bus_ack, zero fill.
    input  wire logic [i2cms_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: command[2:0].
    input  wire logic [i2cms_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // Fields from bit 0: scl, sda, read_byte[7:0], ack_level, zero fill.
    output logic [i2cms_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                     m_axis_tlast
);

    logic                 r_in_vld;
    logic [2:0]           r_cmd;
    logic [7:0]           r_write_byte;
    logic [7:0]           r_bus_bits;
    logic                 r_bus_ack;
    i2cms_pkg::t_beat_idx r_beat;
    logic                 r_scl;
    logic                 r_sda;

    i2cms_pkg::t_beat     w_beat;
    logic                 w_can_load;
    logic                 w_launch;
    logic                 w_advance;
    logic                 w_done;
    logic                 w_accept;

    i2cms_beat_gen u_beat_gen (
        .i_cmd        (r_cmd),
        .i_beat       (r_beat),
        .i_write_byte (r_write_byte),
        .i_bus_bits   (r_bus_bits),
        .i_bus_ack    (r_bus_ack),
        .i_scl_cur    (r_scl),
        .i_sda_cur    (r_sda),
        .o_beat       (w_beat)
    );

    assign w_launch  = r_in_vld && w_beat.emit && w_can_load;
    assign w_advance = r_in_vld && (w_can_load || !w_beat.emit);
    assign w_done    = w_advance && w_beat.last;

    assign s_axis_tready = !r_in_vld || w_done;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_beat   <= '0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_done) begin
                r_in_vld <= 1'b0;
            end
            if (w_done) begin
                r_beat <= '0;
            end else if (w_advance) begin
                r_beat <= r_beat + i2cms_pkg::t_beat_idx'(1);
            end
            if (w_launch) begin
                r_scl <= w_beat.scl;
                r_sda <= w_beat.sda;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= s_axis_tuser;
            r_write_byte <= s_axis_tdata[7:0];
            r_bus_bits   <= s_axis_tdata[15:8];
            r_bus_ack    <= s_axis_tdata[16];
        end
    end

    i2cms_out_stage u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_launch),
        .i_beat        (w_beat),
        .o_can_load    (w_can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef ASSERT_OFF
    a_beat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat <= i2cms_pkg::WRITE_LAST_BEAT)
        else $error("beat counter ran past the longest run");

    a_idle_beat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> r_beat == '0)
        else $error("beat counter not cleared with no command pending");

    a_run_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> r_in_vld)
        else $error("non-final item shown but command already retired");

    a_level_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_launch |=> (r_scl == m_axis_tdata[0] && r_sda == m_axis_tdata[1]))
        else $error("bus level state differs from last emitted item");
`endif

endmodule

`default_nettype wire
